### hw/rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared widths, codes and the command type of the nearest palette color
// search unit.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int CHAN_W               = 8;
  localparam int INDEX_W              = 8;
  localparam int SIZE_W               = 9;
  localparam int ENTRY_W              = 3 * CHAN_W;
  localparam int SQ_W                 = 2 * CHAN_W;
  // Three squared 8-bit differences sum to at most 195075, which fits 18 bits.
  localparam int DIST_W               = SQ_W + 2;
  localparam int DEFAULT_PALETTE_DEPTH = 256;
  localparam int QUEUE_DEPTH          = 2;

  // Starting distance of a search. All ones lies above any real distance,
  // so the first entry always wins, as with a start of 0x7FFFFFFF.
  localparam logic [DIST_W-1:0] DIST_START = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              is_query;
    logic [INDEX_W-1:0] entry_index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } npcs_cmd_t;

endpackage

### hw/rtl/npcs_if.sv
// ----------------------------------------------------------------------------
// npcs interfaces
// Valid/ready channels for input items, results and the configuration write.
// ----------------------------------------------------------------------------
interface npcs_in_if import npcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;

  modport source (output valid, op, entry_index, red, green, blue, input ready);
  modport sink   (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface npcs_out_if import npcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] best_index;

  modport source (output valid, best_index, input ready);
  modport sink   (input valid, best_index, output ready);
endinterface

interface npcs_cfg_if import npcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/npcs_front.sv
// ----------------------------------------------------------------------------
// npcs_front
// Accepts input items, drops writes beyond the palette depth and queues the
// remaining commands for the search engine.
// ----------------------------------------------------------------------------
module npcs_front import npcs_pkg::*; #(
  parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  npcs_in_if.sink   item,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output npcs_cmd_t cmd
);

  localparam int AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int IW  = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  npcs_cmd_t      queue [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  logic [IW:0] wide_index;
  logic        in_range;
  logic        keep;
  logic        push;
  logic        pop;
  npcs_cmd_t   incoming;

  assign wide_index = (IW + 1)'(item.entry_index);
  assign in_range   = wide_index < (IW + 1)'(PALETTE_DEPTH);
  assign keep       = (item.op == OP_QUERY) || in_range;

  assign incoming.is_query    = (item.op == OP_QUERY);
  assign incoming.entry_index = item.entry_index;
  assign incoming.red         = item.red;
  assign incoming.green       = item.green;
  assign incoming.blue        = item.blue;

  assign item.ready = (count != QCW'(QUEUE_DEPTH));
  // A write outside the palette completes its transaction but is not queued.
  assign push       = item.valid && item.ready && keep;
  assign cmd_valid  = (count != '0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QUEUE_DEPTH))
    else $error("command queue count beyond its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == QCW'(QUEUE_DEPTH)) |-> !push)
    else $error("push into a full command queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("command queue count did not follow a push");

endmodule

### hw/rtl/npcs_back.sv
// ----------------------------------------------------------------------------
// npcs_back
// Executes queued commands: stores palette entries and scans the palette
// for the entry nearest to a query color, one entry per cycle.
// ----------------------------------------------------------------------------
module npcs_back import npcs_pkg::*; #(
  parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  npcs_cmd_t cmd,
  npcs_cfg_if.sink  cfg,
  npcs_out_if.source result
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam int NW = (CW > SIZE_W) ? CW : SIZE_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state;
  logic [SIZE_W-1:0]  palette_size;
  logic [CHAN_W-1:0]  tgt_red;
  logic [CHAN_W-1:0]  tgt_green;
  logic [CHAN_W-1:0]  tgt_blue;
  logic [CW-1:0]      count_n;
  logic [CW-1:0]      rd_cnt;
  logic               v1;
  logic [AW-1:0]      idx1;
  logic               v2;
  logic [AW-1:0]      idx2;
  logic [SQ_W-1:0]    sq_red;
  logic [SQ_W-1:0]    sq_green;
  logic [SQ_W-1:0]    sq_blue;
  logic [DIST_W-1:0]  best_d;
  logic [AW-1:0]      best_i;
  logic               out_valid;
  logic [INDEX_W-1:0] out_index;

  logic               pop;
  logic               ram_we;
  logic [ENTRY_W-1:0] rdata;
  logic [NW-1:0]      size_wide;
  logic [CW-1:0]      size_clamped;
  logic [DIST_W-1:0]  sum_sq;
  logic               load_out;

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  assign cfg.ready = 1'b1;
  assign cmd_ready = (state == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign ram_we    = pop && !cmd.is_query;

  assign size_wide    = NW'(palette_size);
  assign size_clamped = (size_wide > NW'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                         : CW'(size_wide);

  assign sum_sq   = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  assign load_out = (state == ST_DONE) && (!out_valid || result.ready);

  assign result.valid      = out_valid;
  assign result.best_index = out_index;

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(cmd.entry_index)),
    .wdata ({cmd.blue, cmd.green, cmd.red}),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
    end else if (cfg.valid && cfg.ready) begin
      palette_size <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop && cmd.is_query) begin
            state <= (size_clamped == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_cnt == count_n - CW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Query setup and the read address counter.
  always_ff @(posedge clk) begin
    if (pop && cmd.is_query) begin
      tgt_red   <= cmd.red;
      tgt_green <= cmd.green;
      tgt_blue  <= cmd.blue;
      count_n   <= size_clamped;
      rd_cnt    <= '0;
    end else if (state == ST_SCAN) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
  end

  // Three stage scan: memory read, squared differences, sum and compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_SCAN);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1     <= rd_cnt[AW-1:0];
    idx2     <= idx1;
    sq_red   <= chan_sq(rdata[CHAN_W-1:0], tgt_red);
    sq_green <= chan_sq(rdata[2*CHAN_W-1:CHAN_W], tgt_green);
    sq_blue  <= chan_sq(rdata[3*CHAN_W-1:2*CHAN_W], tgt_blue);
  end

  // Entries arrive in ascending order, so a strict compare keeps the lowest
  // index among equal distances.
  always_ff @(posedge clk) begin
    if (pop && cmd.is_query) begin
      best_d <= DIST_START;
      best_i <= '0;
    end else if (v2 && (sum_sq < best_d)) begin
      best_d <= sum_sq;
      best_i <= idx2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index <= INDEX_W'(best_i);
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!v1 && !v2))
    else $error("scan pipeline busy while the engine is idle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_cnt < count_n))
    else $error("scan read address beyond the search size");

  a_done_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!v1 && !v2))
    else $error("result taken before the scan pipeline drained");

endmodule

### hw/rtl/nearest_palette_color_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// Palette store with a nearest color search by squared RGB distance.
// ----------------------------------------------------------------------------
// Channels: "item" carries input transactions. With op write, red, green and
// blue are stored at entry_index; a write beyond the palette depth is dropped.
// With op query, the unit scans entries 0 to palette_size-1 (capped at the
// palette depth) and returns on "result" the index of the entry at the
// smallest squared distance, lowest index on ties, index 0 for an empty
// palette. "cfg" writes palette_size. Items pass through a two-entry command
// queue into the search engine, which runs one command at a time. A write
// is done when the engine accepts it. A query occupies the engine through
// its accept, a scan that reads one palette entry per cycle from the single
// read port, the drain of the scan pipeline, and the load of the result. A
// query on an empty palette skips the scan and the drain.
// The result sits in an output register; while the receiver stalls, the
// engine still executes queued writes and finishes the next query, then holds
// it until the register frees. Reset clears the queue, the engine and
// palette_size; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_unit import npcs_pkg::*; #(
  parameter int PALETTE_DEPTH = DEFAULT_PALETTE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  npcs_in_if.sink    item,
  npcs_out_if.source result,
  npcs_cfg_if.sink   cfg
);

  logic      cmd_valid;
  logic      cmd_ready;
  npcs_cmd_t cmd;

  npcs_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  npcs_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: nearest palette color search unit
// Palette writes and nearest color queries are sent over the item channel,
// and palette_size is changed between phases. A local palette copy scores
// every accepted query by squared RGB distance, lowest index on ties, and
// each returned best_index is checked against the oldest pending answer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import npcs_pkg::*;

  localparam int PAL_DEPTH      = DEFAULT_PALETTE_DEPTH;
  localparam int ITEM_TARGET    = 1550;
  localparam int QUIET_TAIL     = 150;
  localparam int DRAIN_CYCLES   = 32;
  localparam int MAX_REPORTS    = 40;
  localparam longint TIMEOUT_NS = 8_000_000;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    rgb_t               target;
  } nearest_t;

  typedef enum int {MIX_RANDOM, MIX_FEW, MIX_EXTREME} palette_mix_t;

  logic clk = 1'b0;
  logic rst;

  npcs_in_if  item_if ();
  npcs_out_if result_if ();
  npcs_cfg_if cfg_if ();

  nearest_palette_color_search_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the block state.
  rgb_t        pal_color [PAL_DEPTH];
  int unsigned search_size = 0;
  nearest_t    nearest_expected [$];

  // Stimulus bookkeeping.
  npcs_cmd_t   pending_cmds [$];
  npcs_cmd_t   active_cmd;
  bit          queued_written [PAL_DEPTH];
  rgb_t        few_colors [4];
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int          src_gap  = 0;
  int          sink_gap = 0;

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned writes_done    = 0;
  int unsigned queries_done   = 0;
  int unsigned ties_seen      = 0;
  int unsigned empty_searches = 0;
  int unsigned results_checked = 0;
  int unsigned size_writes    = 0;
  int unsigned errors         = 0;

  function automatic void score_query(input rgb_t target);
    int unsigned limit;
    int unsigned best_dist;
    int unsigned best;
    int unsigned sq_dist;
    int          dr, dg, db;
    bit          tied;
    nearest_t    answer;
    limit = (search_size > PAL_DEPTH) ? PAL_DEPTH : search_size;
    best_dist = 32'h7FFF_FFFF;
    best = 0;
    tied = 1'b0;
    for (int unsigned i = 0; i < limit; i++) begin
      dr = int'(pal_color[i].red) - int'(target.red);
      dg = int'(pal_color[i].green) - int'(target.green);
      db = int'(pal_color[i].blue) - int'(target.blue);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best = i;
        tied = 1'b0;
      end else if (sq_dist == best_dist) begin
        tied = 1'b1;
      end
    end
    if (tied) ties_seen++;
    if (limit == 0) empty_searches++;
    answer.index = best[INDEX_W-1:0];
    answer.target = target;
    nearest_expected.push_back(answer);
  endfunction

  function automatic void apply_command(input npcs_cmd_t cmd);
    rgb_t c;
    c.red = cmd.red;
    c.green = cmd.green;
    c.blue = cmd.blue;
    if (cmd.is_query == OP_QUERY) begin
      score_query(c);
      queries_done++;
    end else begin
      pal_color[cmd.entry_index] = c;
      writes_done++;
    end
  endfunction

  // Item driver.
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        apply_command(active_cmd);
        items_accepted++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          active_cmd = pending_cmds.pop_front();
          item_if.valid       <= 1'b1;
          item_if.op          <= active_cmd.is_query;
          item_if.entry_index <= active_cmd.entry_index;
          item_if.red         <= active_cmd.red;
          item_if.green       <= active_cmd.green;
          item_if.blue        <= active_cmd.blue;
          if (src_idle_en && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 6);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin : check_results
    nearest_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (nearest_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no query pending: expected none, actual best_index %0d",
                     $time, result_if.best_index);
        end else begin
          want = nearest_expected.pop_front();
          results_checked++;
          if (result_if.best_index !== want.index) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: best_index for target (%0d,%0d,%0d): expected %0d, actual %0d",
                       $time, want.target.red, want.target.green, want.target.blue,
                       want.index, result_if.best_index);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 6);
      end
    end
  end

  function automatic void queue_write(input int unsigned idx, input rgb_t c);
    npcs_cmd_t cmd;
    cmd.is_query    = OP_WRITE;
    cmd.entry_index = idx[INDEX_W-1:0];
    cmd.red         = c.red;
    cmd.green       = c.green;
    cmd.blue        = c.blue;
    queued_written[idx[INDEX_W-1:0]] = 1'b1;
    pending_cmds.push_back(cmd);
    items_queued++;
  endfunction

  function automatic void queue_query(input rgb_t c);
    npcs_cmd_t cmd;
    cmd.is_query    = OP_QUERY;
    cmd.entry_index = INDEX_W'($urandom);  // a query ignores the index
    cmd.red         = c.red;
    cmd.green       = c.green;
    cmd.blue        = c.blue;
    pending_cmds.push_back(cmd);
    items_queued++;
  endfunction

  function automatic logic [CHAN_W-1:0] extreme_chan();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v);
    int n;
    n = int'(v) + $urandom_range(0, 6) - 3;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return n[CHAN_W-1:0];
  endfunction

  function automatic rgb_t pick_color(input palette_mix_t mix);
    rgb_t c;
    case (mix)
      MIX_FEW:     c = few_colors[$urandom_range(0, 3)];
      MIX_EXTREME: begin
        c.red = extreme_chan();
        c.green = extreme_chan();
        c.blue = extreme_chan();
      end
      default:     c = ENTRY_W'($urandom);
    endcase
    return c;
  endfunction

  // Targets that land on, next to, or halfway between palette entries make
  // exact hits and equal distances common.
  function automatic rgb_t pick_target(input int unsigned reach);
    rgb_t a, b, t;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    t = ENTRY_W'($urandom);
    if (roll < 35 || reach == 0) return t;
    a = pal_color[$urandom_range(0, reach - 1)];
    b = pal_color[$urandom_range(0, reach - 1)];
    if (roll < 55) begin
      t = a;
    end else if (roll < 70) begin
      t.red = extreme_chan();
      t.green = extreme_chan();
      t.blue = extreme_chan();
    end else if (roll < 85) begin
      t.red   = CHAN_W'((9'(a.red) + 9'(b.red)) >> 1);
      t.green = CHAN_W'((9'(a.green) + 9'(b.green)) >> 1);
      t.blue  = CHAN_W'((9'(a.blue) + 9'(b.blue)) >> 1);
    end else begin
      t.red = nudge(a.red);
      t.green = nudge(a.green);
      t.blue = nudge(a.blue);
    end
    return t;
  endfunction

  task automatic wait_for_drain();
    while (items_accepted != items_queued || nearest_expected.size() != 0) @(posedge clk);
    // Writes queued behind the last query may still be in the engine.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_palette_size(input int unsigned size);
    wait_for_drain();
    cfg_if.data  <= size[SIZE_W-1:0];
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    search_size = size;
    size_writes++;
  endtask

  task automatic run_phase(input int unsigned size);
    int unsigned reach;
    int          body;
    bit          quiet;
    palette_mix_t mix;
    mix = palette_mix_t'($urandom_range(0, 2));
    for (int k = 0; k < 4; k++) few_colors[k] = ENTRY_W'($urandom);
    quiet = (items_queued >= ITEM_TARGET - QUIET_TAIL);
    set_palette_size(size);
    src_idle_en  = !quiet && ($urandom_range(0, 3) != 0);
    sink_idle_en = !quiet && ($urandom_range(0, 3) != 0);
    reach = (size > PAL_DEPTH) ? PAL_DEPTH : size;
    // Every entry a query can reach gets written first.
    for (int unsigned i = 0; i < reach; i++)
      if (!queued_written[i]) queue_write(i, pick_color(mix));
    body = (size > 64) ? $urandom_range(4, 10) : $urandom_range(20, 60);
    for (int k = 0; k < body; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        if (reach > 0 && $urandom_range(0, 1) == 1)
          queue_write($urandom_range(0, reach - 1), pick_color(mix));
        else
          queue_write($urandom_range(0, PAL_DEPTH - 1), pick_color(mix));
      end else begin
        queue_query(pick_target(reach));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned edge_sizes [6];
    int unsigned roll;
    int unsigned size;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.op = OP_WRITE;
    item_if.entry_index = '0;
    item_if.red = '0;
    item_if.green = '0;
    item_if.blue = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    edge_sizes = '{256, 511, 0, 255, 257, 1};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // palette_size comes out of reset at zero, so these search nothing.
    queue_query(24'hFFFFFF);
    queue_query(24'h000000);
    queue_write(0, 24'h000000);
    queue_write(1, 24'hFFFFFF);
    queue_write(2, 24'hFFFFFF);
    queue_write(3, {8'd32, 8'd64, 8'd128});
    queue_write(255, 24'h00FF00);
    set_palette_size(4);
    queue_query(24'h000000);
    queue_query(24'hFFFFFF);              // entries 1 and 2 are equal
    queue_query({8'd32, 8'd64, 8'd128});
    queue_query({8'd16, 8'd32, 8'd64});   // equally far from entries 0 and 3
    queue_query({8'd127, 8'd127, 8'd127});
    queue_query({8'd255, 8'd0, 8'd255});
    queue_query({8'd200, 8'd200, 8'd200});
    set_palette_size(1);
    queue_query(24'hFFFFFF);

    // Size extremes first, including sizes beyond the palette depth.
    foreach (edge_sizes[p]) run_phase(edge_sizes[p]);
    // Mostly small palettes keep the searches short.
    while (items_queued < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) size = 0;
      else if (roll < 80) size = $urandom_range(1, 16);
      else if (roll < 93) size = $urandom_range(17, 64);
      else size = $urandom_range(65, 511);
      run_phase(size);
    end

    wait_for_drain();
    $display("Sent %0d palette writes and %0d queries; %0d results checked.",
             writes_done, queries_done, results_checked);
    $display("palette_size set %0d times; %0d queries hit a distance tie, %0d had no entries.",
             size_writes, ties_seen, empty_searches);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout at %0t with %0d results outstanding.", $time, nearest_expected.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
